// ----- hdl/programmable_io_interrupt_timer_macros.svh -----
// Assertion macros used by programmable_io_interrupt_timer.sv.
`ifndef PROGRAMMABLE_IO_INTERRUPT_TIMER_MACROS_SVH
`define PROGRAMMABLE_IO_INTERRUPT_TIMER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PIT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pit assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pit assertion failed");

`endif

// ----- hdl/pit_pkg.sv -----
`timescale 1ns / 1ps

package pit_pkg;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_READ  = 3'd1,
		ACT_TICK  = 3'd2,
		ACT_RAISE = 3'd3,
		ACT_CLEAR = 3'd4
	} action_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  bit_index;
		logic        write_bit;
		logic [15:0] int_lines;
		logic [7:0]  key_row;
		logic        caps_lock;
		logic        cassette_in;
	} cmd_item_t;

	typedef struct packed {
		logic       read_bit;
		logic       int_request;
		logic [1:0] int_level;
		logic [2:0] key_column;
		logic       alpha_lock;
		logic       motor_one;
		logic       motor_two;
		logic       audio_gate;
		logic       cassette_out;
	} rsp_item_t;

	localparam logic [15:0] LVL_EXT   = 16'h0002;
	localparam logic [15:0] LVL_VDP   = 16'h0004;
	localparam logic [15:0] LVL_CLOCK = 16'h0008;

	localparam logic [1:0] LEVEL_NONE  = 2'd0;
	localparam logic [1:0] LEVEL_EXT   = 2'd1;
	localparam logic [1:0] LEVEL_VDP   = 2'd2;
	localparam logic [1:0] LEVEL_CLOCK = 2'd3;

	localparam logic [4:0] BIT_MODE      = 5'd0;
	localparam logic [4:0] BIT_INT_LAST  = 5'd14;
	localparam logic [4:0] BIT_COL_FIRST = 5'd18;
	localparam logic [4:0] BIT_COL_LAST  = 5'd20;
	localparam logic [4:0] BIT_LAT_FIRST = 5'd21;
	localparam logic [4:0] BIT_LAT_LAST  = 5'd25;
	localparam logic [4:0] BIT_PEND_LAST = 5'd2;
	localparam logic [4:0] BIT_KEY_FIRST = 5'd3;
	localparam logic [4:0] BIT_KEY_LAST  = 5'd10;
	localparam logic [4:0] BIT_ALPHA_KEY = 5'd7;
	localparam logic [4:0] BIT_MODE_A    = 5'd12;
	localparam logic [4:0] BIT_MODE_B    = 5'd16;
	localparam logic [4:0] BIT_MODE_C    = 5'd17;
	localparam logic [4:0] BIT_CAPS      = 5'd21;
	localparam logic [4:0] BIT_CASSETTE  = 5'd27;

endpackage

// ----- hdl/pit_if.sv -----
`timescale 1ns / 1ps

interface pit_cmd_if import pit_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pit_rsp_if import pit_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/programmable_io_interrupt_timer.sv -----
// Channel  Direction  Contents
// cmd      in         action, bit index, write bit, interrupt lines, key row, caps, cassette in
// rsp      out        read bit, interrupt request and level, column and output latches
//
// An accepted item waits in the input register until rsp is not stalled, then moves into the
// result register, where its result is offered. One item is accepted per cycle unless rsp
// stalls; the state updates as an item moves into the result register.
// While rsp is stalled the input register still takes one item, then cmd.ready drops.
// arst_n clears all timer, interrupt and latch state to zero and empties both registers.
`timescale 1ns / 1ps
`include "programmable_io_interrupt_timer_macros.svh"

module programmable_io_interrupt_timer import pit_pkg::*; (
	input logic clk,
	input logic arst_n,
	pit_cmd_if.sink cmd,
	pit_rsp_if.source rsp
);

	logic        valid_s1;
	cmd_item_t   item_s1;
	logic        out_valid_q;
	rsp_item_t   out_q;

	logic [15:0] enable_q, pending_q;
	logic [1:0]  level_q;
	logic        clock_mode_q;
	logic [14:0] latched_q, active_q, dec_q, frozen_q;
	logic [2:0]  column_q;
	logic [4:0]  latches_q;

	logic [15:0] enable_n, pending_n, live;
	logic [1:0]  level_n;
	logic        clock_mode_n;
	logic [14:0] latched_n, active_n, dec_n, frozen_n;
	logic [2:0]  column_n;
	logic [4:0]  latches_n;
	logic        do_pick, req, rb;

	logic        advance, step, mode_step;
	logic [4:0]  bidx, bm1, bm3, bm18, bm21;
	logic [15:0] m, lower;
	logic        d;

	function automatic logic key_bit(input logic [7:0] row, input logic [2:0] idx);
		key_bit = row[idx];
	endfunction

	assign advance   = !out_valid_q || rsp.ready;
	assign step      = valid_s1 && advance;
	assign mode_step = step && item_s1.action == ACT_WRITE && item_s1.bit_index == BIT_MODE;
	assign cmd.ready = !valid_s1 || advance;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign bidx  = item_s1.bit_index;
	assign d     = item_s1.write_bit;
	assign bm1   = bidx - 5'd1;
	assign bm3   = bidx - BIT_KEY_FIRST;
	assign bm18  = bidx - BIT_COL_FIRST;
	assign bm21  = bidx - BIT_LAT_FIRST;
	assign m     = 16'd1 << bidx;
	assign lower = m - 16'd1;

	always_comb begin
		enable_n     = enable_q;
		pending_n    = pending_q;
		clock_mode_n = clock_mode_q;
		latched_n    = latched_q;
		active_n     = active_q;
		dec_n        = dec_q;
		frozen_n     = frozen_q;
		column_n     = column_q;
		latches_n    = latches_q;
		do_pick      = 1'b0;
		rb           = 1'b0;
		unique case (item_s1.action)
			ACT_WRITE: begin
				if (bidx == BIT_MODE) begin
					if (!d) begin
						active_n     = latched_q;
						dec_n        = latched_q;
						clock_mode_n = 1'b0;
					end else begin
						frozen_n     = (active_q == '0 || dec_q == active_q) ? '0 : dec_q;
						clock_mode_n = 1'b1;
					end
				end else if (bidx <= BIT_INT_LAST) begin
					if (clock_mode_q) begin
						latched_n[bidx[3:0]] = d;
					end else begin
						enable_n[bidx[3:0]] = d;
						if (d && (pending_q & m) != '0) begin
							pending_n = pending_q & ~m;
							do_pick   = 1'b1;
						end
					end
				end else if (bidx >= BIT_COL_FIRST && bidx <= BIT_COL_LAST) begin
					column_n[bm18[1:0]] = d;
				end else if (bidx >= BIT_LAT_FIRST && bidx <= BIT_LAT_LAST) begin
					latches_n[bm21[2:0]] = d;
				end
			end
			ACT_READ: begin
				if (bidx == BIT_MODE) begin
					rb = 1'b1;
				end else if (bidx <= BIT_KEY_LAST) begin
					if (clock_mode_q) begin
						rb = frozen_q[bm1[3:0]];
					end else if (bidx <= BIT_PEND_LAST) begin
						rb = enable_q[bidx[3:0]] && !pending_q[bidx[3:0]];
					end else if (enable_q[bidx[3:0]]) begin
						rb = (pending_q & lower) == '0 && pending_q[bidx[3:0]];
					end else begin
						rb = !(key_bit(item_s1.key_row, bm3[2:0]) ||
							(bidx == BIT_ALPHA_KEY && item_s1.caps_lock && !latches_q[0]));
					end
				end else if (bidx == BIT_MODE_A || bidx == BIT_MODE_B || bidx == BIT_MODE_C) begin
					rb = !clock_mode_q;
				end else if (bidx == BIT_CAPS) begin
					rb = item_s1.caps_lock;
				end else if (bidx == BIT_CASSETTE) begin
					rb = item_s1.cassette_in;
				end
			end
			ACT_TICK: begin
				if (!clock_mode_q && active_q != '0) begin
					if (dec_q == '0) begin
						dec_n = active_q;
						if ((enable_q & LVL_CLOCK) != '0) begin
							pending_n = pending_q | LVL_CLOCK;
							do_pick   = 1'b1;
						end
					end else begin
						dec_n = dec_q - 15'd1;
					end
				end
			end
			ACT_RAISE: begin
				if ((enable_q & item_s1.int_lines) != '0) begin
					pending_n = pending_q | item_s1.int_lines;
					do_pick   = 1'b1;
				end
			end
			ACT_CLEAR: begin
				if ((pending_q & item_s1.int_lines) != '0) begin
					pending_n = pending_q & ~item_s1.int_lines;
					do_pick   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		live    = pending_n & enable_n;
		level_n = level_q;
		if (do_pick && live != '0) begin
			priority if (live[1]) begin
				level_n = LEVEL_EXT;
			end else if (live[2]) begin
				level_n = LEVEL_VDP;
			end else if (live[3]) begin
				level_n = LEVEL_CLOCK;
			end else begin
				level_n = LEVEL_NONE;
			end
		end
		req = do_pick && live != '0 && level_n != LEVEL_NONE;
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
		if (step) begin
			out_q.read_bit     <= rb;
			out_q.int_request  <= req;
			out_q.int_level    <= level_n;
			out_q.key_column   <= column_n;
			out_q.alpha_lock   <= latches_n[0];
			out_q.motor_one    <= latches_n[1];
			out_q.motor_two    <= latches_n[2];
			out_q.audio_gate   <= latches_n[3];
			out_q.cassette_out <= latches_n[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			enable_q     <= '0;
			pending_q    <= '0;
			level_q      <= '0;
			clock_mode_q <= 1'b0;
			latched_q    <= '0;
			active_q     <= '0;
			dec_q        <= '0;
			frozen_q     <= '0;
			column_q     <= '0;
			latches_q    <= '0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (step) begin
				enable_q     <= enable_n;
				pending_q    <= pending_n;
				level_q      <= level_n;
				clock_mode_q <= clock_mode_n;
				latched_q    <= latched_n;
				active_q     <= active_n;
				dec_q        <= dec_n;
				frozen_q     <= frozen_n;
				column_q     <= column_n;
				latches_q    <= latches_n;
			end
		end
	end

	`PIT_ASSERT_NOW(a_req_has_level, out_valid_q && out_q.int_request, out_q.int_level != LEVEL_NONE)
	`PIT_ASSERT_NOW(a_dec_in_range, 1'b1, dec_q <= active_q)
	`PIT_ASSERT_NOW(a_ready_when_empty, !out_valid_q, cmd.ready)
	`PIT_ASSERT_NEXT(a_clock_mode_holds_dec, clock_mode_q && !mode_step, $stable(dec_q))

endmodule
